[hdl/recursive_doubling_allreduce_schedule_defines.svh]
// ----------------------------------------------------------------------------
// recursive doubling allreduce schedule: assertion macros
// shared check macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_DOUBLING_ALLREDUCE_SCHEDULE_DEFINES_SVH
`define RECURSIVE_DOUBLING_ALLREDUCE_SCHEDULE_DEFINES_SVH

`ifndef SYNTHESIS

`define RDA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define RDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RDA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define RDA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/rda_pkg.sv]
// ----------------------------------------------------------------------------
// rda_pkg
// types, action codes and microcode table of the allreduce schedule block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rda_pkg;

  localparam int RANK_W      = 10;
  localparam int SIZE_W      = 11;
  localparam int ACT_W       = 3;
  localparam int STEP_W      = 4;
  localparam int MAX_RANKS_D = 1024;

  localparam logic [ACT_W-1:0] ACT_SEND_LOCAL       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RECV_COMBINE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_XCHG_LOCAL_FIRST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_XCHG_RECV_FIRST  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RECV_RESULT      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SEND_RESULT      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_COPY_ONLY        = 3'd6;
  localparam logic [ACT_W-1:0] ACT_INVALID          = 3'd7;

  typedef struct packed {
    logic [RANK_W-1:0] own_rank;
    logic [SIZE_W-1:0] group_size;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [RANK_W-1:0] peer_rank;
    logic [STEP_W-1:0] step_index;
    logic              last_action;
  } result_t;

  // microcode
  localparam int PC_W = 2;

  localparam logic [1:0] UOP_CHECK = 2'd0;
  localparam logic [1:0] UOP_PRE   = 2'd1;
  localparam logic [1:0] UOP_XCHG  = 2'd2;
  localparam logic [1:0] UOP_POST  = 2'd3;

  localparam logic [1:0] COND_NEVER = 2'd0;
  localparam logic [1:0] COND_SKIP  = 2'd1;
  localparam logic [1:0] COND_LOOP  = 2'd2;

  localparam logic [PC_W-1:0] PC_CHECK = 2'd0;
  localparam logic [PC_W-1:0] PC_PRE   = 2'd1;
  localparam logic [PC_W-1:0] PC_XCHG  = 2'd2;
  localparam logic [PC_W-1:0] PC_POST  = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_CHECK: w = '{op: UOP_CHECK, cond: COND_NEVER, target: PC_PRE};
      PC_PRE:   w = '{op: UOP_PRE,   cond: COND_SKIP,  target: PC_POST};
      PC_XCHG:  w = '{op: UOP_XCHG,  cond: COND_LOOP,  target: PC_XCHG};
      PC_POST:  w = '{op: UOP_POST,  cond: COND_NEVER, target: PC_CHECK};
      default:  w = '{op: UOP_CHECK, cond: COND_NEVER, target: PC_CHECK};
    endcase
    return w;
  endfunction

  // largest power of two not above v
  function automatic logic [SIZE_W-1:0] msb_pow2(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] p;
    p = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        p = '0;
        p[i] = 1'b1;
      end
    end
    return p;
  endfunction

endpackage

[hdl/recursive_doubling_allreduce_schedule.sv]
// ----------------------------------------------------------------------------
// recursive_doubling_allreduce_schedule
// emits the recursive doubling allreduce actions of one rank, at most one per cycle
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A four-word microcode
// program then runs: a setup step, a pairing step (it emits only for the
// paired low ranks of a non-power-of-two group), the exchange steps, and the
// final result hand-back of a paired rank. Each action appears on result for
// one cycle with result_valid, in the cycle after the step that made it; the
// receiver cannot stall. busy drops at the edge that registers the last
// action. An invalid or copy-only request emits its single action from the
// setup step.
`timescale 1ns / 1ps
`include "recursive_doubling_allreduce_schedule_defines.svh"

module recursive_doubling_allreduce_schedule
  import rda_pkg::*;
#(
  parameter int MAX_RANKS = MAX_RANKS_D
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    result_valid,
  output result_t result
);

  logic [PC_W-1:0]   pc, pc_next;
  logic [RANK_W-1:0] rank;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] pow2, pow2_next;
  logic [SIZE_W-1:0] extra, extra_next;
  logic              lowpair, lowpair_next;
  logic [RANK_W-1:0] newrank, newrank_next;
  logic [RANK_W-1:0] hop, hop_next;
  logic [STEP_W-1:0] step;

  uword_t            uw;
  logic              emit, last, jump;
  logic [ACT_W-1:0]  act;
  logic [SIZE_W-1:0] peer;
  logic              invalid, lowpair_c, loop_done;
  logic [RANK_W-1:0] m;
  logic [SIZE_W-1:0] hop2, xpeer;

  assign uw = ucode(pc);

  always_comb begin
    invalid   = (size == '0) || (32'(size) > 32'(MAX_RANKS)) || ({1'b0, rank} >= size);
    lowpair_c = {2'b00, rank} < {extra, 1'b0};
    m         = newrank ^ hop;
    hop2      = {hop, 1'b0};
    loop_done = hop2 >= pow2;
    xpeer     = ({1'b0, m} < extra) ? {m, 1'b1} : ({1'b0, m} + extra);

    emit         = 1'b0;
    last         = 1'b0;
    act          = ACT_INVALID;
    peer         = '0;
    pow2_next    = pow2;
    extra_next   = extra;
    lowpair_next = lowpair;
    newrank_next = newrank;
    hop_next     = hop;

    unique case (uw.op)
      UOP_CHECK: begin
        pow2_next  = msb_pow2(size);
        extra_next = size - msb_pow2(size);
        if (invalid) begin
          emit = 1'b1;
          last = 1'b1;
          act  = ACT_INVALID;
        end else if (size == SIZE_W'(1)) begin
          emit = 1'b1;
          last = 1'b1;
          act  = ACT_COPY_ONLY;
        end
      end
      UOP_PRE: begin
        lowpair_next = lowpair_c;
        newrank_next = lowpair_c ? (rank >> 1) : (rank - extra[RANK_W-1:0]);
        hop_next     = RANK_W'(1);
        if (lowpair_c) begin
          emit = 1'b1;
          act  = rank[0] ? ACT_RECV_COMBINE : ACT_SEND_LOCAL;
          peer = rank[0] ? {1'b0, rank - RANK_W'(1)} : ({1'b0, rank} + SIZE_W'(1));
        end
      end
      UOP_XCHG: begin
        emit     = 1'b1;
        last     = loop_done && !lowpair;
        act      = ({1'b0, rank} < xpeer) ? ACT_XCHG_LOCAL_FIRST : ACT_XCHG_RECV_FIRST;
        peer     = xpeer;
        hop_next = hop2[RANK_W-1:0];
      end
      UOP_POST: begin
        emit = lowpair;
        last = 1'b1;
        act  = rank[0] ? ACT_SEND_RESULT : ACT_RECV_RESULT;
        peer = rank[0] ? {1'b0, rank - RANK_W'(1)} : ({1'b0, rank} + SIZE_W'(1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    unique case (uw.cond)
      COND_SKIP: jump = lowpair_c && !rank[0];
      COND_LOOP: jump = !loop_done;
      default:   jump = 1'b0;
    endcase

    pc_next = jump ? uw.target : (pc + PC_W'(1));
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pc           <= PC_CHECK;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= busy && emit;
      if (start && !busy) begin
        busy <= 1'b1;
        pc   <= PC_CHECK;
        step <= '0;
      end else if (busy) begin
        pc <= pc_next;
        if (emit) begin
          step <= step + STEP_W'(1);
          if (last) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rank <= req.own_rank;
      size <= req.group_size;
    end
    if (busy) begin
      pow2    <= pow2_next;
      extra   <= extra_next;
      lowpair <= lowpair_next;
      newrank <= newrank_next;
      hop     <= hop_next;
    end
    if (busy && emit) begin
      result.action      <= act;
      result.peer_rank   <= peer[RANK_W-1:0];
      result.step_index  <= step;
      result.last_action <= last;
    end
  end

  `RDA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `RDA_ASSERT_IMPLIES(a_last_idle, clk, rst, result_valid && result.last_action, !busy)
  `RDA_ASSERT_IMPLIES(a_mid_busy, clk, rst, result_valid && !result.last_action, busy)
  `RDA_ASSERT_IMPLIES(a_steps_back_to_back, clk, rst,
    result_valid && (result.step_index != '0), $past(result_valid))
  `RDA_ASSERT_IMPLIES(a_single_actions, clk, rst,
    result_valid && ((result.action == ACT_INVALID) || (result.action == ACT_COPY_ONLY)),
    result.last_action && (result.step_index == '0))

endmodule

[tb/tb_recursive_doubling_allreduce_schedule.sv]
// ----------------------------------------------------------------------------
// tb_recursive_doubling_allreduce_schedule
// self-checking bench for the allreduce schedule generator
// ----------------------------------------------------------------------------
// Requests go in on the start/busy handshake. Each accepted item has its
// action list worked out by a local schedule planner, or typed in for the
// plain cases, and queued. Every strobed result is checked field by field
// against the oldest queued action. A directed table covers group size
// extremes, out-of-range ranks and sizes, copy-only and the pairing ranks of
// odd groups. A random part follows under three sender idling phases.
`timescale 1ns / 1ps

module tb_recursive_doubling_allreduce_schedule;
  import rda_pkg::*;

  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM   = 420;

  typedef struct packed {
    req_t    rq;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  req_t    req;
  logic    result_valid;
  result_t result;

  result_t  pending_actions[$];
  dir_row_t dir_table [0:N_DIRECTED-1];
  int       error_count = 0;
  int       idle_pct    = 15;

  recursive_doubling_allreduce_schedule dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic result_t make_action(input logic [ACT_W-1:0] act, input int peer,
                                          input int step, input logic last);
    result_t r;
    r.action      = act;
    r.peer_rank   = RANK_W'(peer);
    r.step_index  = STEP_W'(step);
    r.last_action = last;
    return r;
  endfunction

  // queue the action list of one rank
  function automatic void plan_schedule(input req_t r);
    int               rank;
    int               size;
    int               pow2;
    int               extra;
    int               crank;
    int               m;
    int               peer;
    int               cnt;
    bit               sends_away;
    logic [ACT_W-1:0] acts [0:15];
    int               peers [0:15];
    rank = int'(r.own_rank);
    size = int'(r.group_size);
    cnt = 0;
    sends_away = 1'b0;
    if (size == 0 || size > MAX_RANKS_D || rank >= size) begin
      pending_actions.push_back(make_action(ACT_INVALID, 0, 0, 1'b1));
      return;
    end
    if (size == 1) begin
      pending_actions.push_back(make_action(ACT_COPY_ONLY, 0, 0, 1'b1));
      return;
    end
    pow2 = 1;
    while ((pow2 << 1) <= size) pow2 = pow2 << 1;
    extra = size - pow2;
    crank = rank - extra;
    if (rank < 2 * extra) begin
      if (rank % 2 == 0) begin
        acts[cnt] = ACT_SEND_LOCAL;
        peers[cnt] = rank + 1;
        sends_away = 1'b1;
      end else begin
        acts[cnt] = ACT_RECV_COMBINE;
        peers[cnt] = rank - 1;
        crank = rank >> 1;
      end
      cnt++;
    end
    if (!sends_away) begin
      for (int d = 1; d < pow2; d = d << 1) begin
        m = crank ^ d;
        peer = (m < extra) ? (2 * m + 1) : (m + extra);
        acts[cnt] = (rank < peer) ? ACT_XCHG_LOCAL_FIRST : ACT_XCHG_RECV_FIRST;
        peers[cnt] = peer;
        cnt++;
      end
    end
    if (rank < 2 * extra) begin
      if (rank % 2 == 0) begin
        acts[cnt] = ACT_RECV_RESULT;
        peers[cnt] = rank + 1;
      end else begin
        acts[cnt] = ACT_SEND_RESULT;
        peers[cnt] = rank - 1;
      end
      cnt++;
    end
    if (cnt > 12) cnt = 12;
    for (int k = 0; k < cnt; k++)
      pending_actions.push_back(make_action(acts[k], peers[k], k, k == cnt - 1));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_actions.size() == 0) begin
        report_mismatch("unexpected action", int'(result.action), -1);
      end else begin
        want = pending_actions.pop_front();
        if (result.action !== want.action)
          report_mismatch("action", int'(result.action), int'(want.action));
        if (result.peer_rank !== want.peer_rank)
          report_mismatch("peer_rank", int'(result.peer_rank), int'(want.peer_rank));
        if (result.step_index !== want.step_index)
          report_mismatch("step_index", int'(result.step_index), int'(want.step_index));
        if (result.last_action !== want.last_action)
          report_mismatch("last_action", int'(result.last_action), int'(want.last_action));
      end
    end
  end

  // hold start until the item is taken, then queue its actions
  task automatic send_item(input req_t r, input logic typed, input result_t typed_res);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed) pending_actions.push_back(typed_res);
    else plan_schedule(r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
  endtask

  function automatic req_t random_request();
    req_t r;
    int   sel;
    int   size;
    sel = $urandom_range(99);
    if (sel < 10) begin
      r.group_size = SIZE_W'($urandom_range(2047, 0));
      r.own_rank   = RANK_W'($urandom_range(1023, 0));
      return r;
    end else if (sel < 25) begin
      size = 1 << $urandom_range(10, 0);
    end else if (sel < 40) begin
      size = $urandom_range(16, 1);
    end else begin
      size = $urandom_range(1024, 1);
    end
    r.group_size = SIZE_W'(size);
    r.own_rank   = RANK_W'($urandom_range(size - 1, 0));
    return r;
  endfunction

  initial begin
    int   third;
    req_t r;
    dir_table = '{
      '{'{10'd0,    11'd1},    1'b1, '{ACT_COPY_ONLY, 10'd0, 4'd0, 1'b1}},
      '{'{10'd0,    11'd0},    1'b1, '{ACT_INVALID,   10'd0, 4'd0, 1'b1}},
      '{'{10'd1023, 11'd0},    1'b1, '{ACT_INVALID,   10'd0, 4'd0, 1'b1}},
      '{'{10'd1,    11'd1},    1'b1, '{ACT_INVALID,   10'd0, 4'd0, 1'b1}},
      '{'{10'd5,    11'd3},    1'b1, '{ACT_INVALID,   10'd0, 4'd0, 1'b1}},
      '{'{10'd0,    11'd1025}, 1'b1, '{ACT_INVALID,   10'd0, 4'd0, 1'b1}},
      '{'{10'd1023, 11'd2047}, 1'b1, '{ACT_INVALID,   10'd0, 4'd0, 1'b1}},
      '{'{10'd1023, 11'd1023}, 1'b1, '{ACT_INVALID,   10'd0, 4'd0, 1'b1}},
      '{'{10'd0,    11'd2},    1'b0, '0},
      '{'{10'd1,    11'd2},    1'b0, '0},
      '{'{10'd0,    11'd3},    1'b0, '0},
      '{'{10'd1,    11'd3},    1'b0, '0},
      '{'{10'd2,    11'd3},    1'b0, '0},
      '{'{10'd0,    11'd5},    1'b0, '0},
      '{'{10'd4,    11'd5},    1'b0, '0},
      '{'{10'd3,    11'd6},    1'b0, '0},
      '{'{10'd0,    11'd1024}, 1'b0, '0},
      '{'{10'd512,  11'd1024}, 1'b0, '0},
      '{'{10'd1023, 11'd1024}, 1'b0, '0},
      '{'{10'd0,    11'd1023}, 1'b0, '0},
      '{'{10'd1021, 11'd1023}, 1'b0, '0},
      '{'{10'd1022, 11'd1023}, 1'b0, '0}
    };
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 15;
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(dir_table[i].rq, dir_table[i].typed, dir_table[i].res);

    third = N_RANDOM / 3;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == third) idle_pct = 48;
      else if (i == 2 * third) idle_pct = 0;
      r = random_request();
      send_item(r, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_actions.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/rda_pkg.sv
hdl/recursive_doubling_allreduce_schedule.sv
tb/tb_recursive_doubling_allreduce_schedule.sv
